### rtl/core/pws_pkg.sv
`default_nettype none

package pws_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CoordW   = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned SizeW    = 14;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRow0C01 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRow0C23 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRow1C01 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRow1C23 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWrowC01 = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWrowC23 = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWidth   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgHeight  = 3'd7;

  // Viewport size after reset.
  localparam logic [SizeW-1:0] WidthRst  = 14'd1920;
  localparam logic [SizeW-1:0] HeightRst = 14'd1080;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                     visible;
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/perspective_world_to_screen.sv
`default_nettype none

// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------
// point in  | start, busy        | point_i  (point_x, point_y, point_z)
// result    | done_o strobe      | result_o (visible, screen_x, screen_y)
// config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// A point is taken every cycle; busy stays low. The restoring divider
// retires one quotient bit per stage. The receiver cannot stall, so the
// pipeline never holds. Reset clears the valid bits and loads the
// configuration defaults.

module perspective_world_to_screen #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire pws_pkg::point_t                    point_i,
  output logic                                    done_o,
  output pws_pkg::result_t                        result_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [pws_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [pws_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import pws_pkg::*;

  localparam int unsigned ProdW = 2 * CoordW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned NW    = 46;              // |clip| * size
  localparam int unsigned DW    = 33;              // 2 * w
  localparam int unsigned QW    = FRAC_BITS + 34;  // quotient bits kept
  localparam int unsigned SW    = QW + 2;
  localparam int unsigned ThrVal = ((1 << FRAC_BITS) + 999) / 1000;
  localparam logic signed [CoordW-1:0] Thr = CoordW'(ThrVal);
  localparam logic signed [ProdW-1:0] Behind = 64'sd100000;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] dq;
  } lane_t;

  typedef struct packed {
    logic                     behind;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic                     negx;
    logic                     negy;
    logic                     ovfx;
    logic                     ovfy;
    logic [DW-1:0]            d;
    lane_t                    lx;
    lane_t                    ly;
  } div_t;

  function automatic logic signed [CoordW-1:0] sat32(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - SumW'(1);
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

  // One restoring division step: bring down a bit, subtract if it fits.
  function automatic lane_t lane_step(lane_t s, logic [DW-1:0] d);
    logic [DW:0] trial;
    lane_t       r;
    trial = {s.rem, s.dq[QW-1]};
    r.dq  = {s.dq[QW-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem   = DW'(trial - {1'b0, d});
      r.dq[0] = 1'b1;
    end else begin
      r.rem = trial[DW-1:0];
    end
    return r;
  endfunction

  // Division setup: seed the remainder with the high numerator bits.
  function automatic lane_t lane_init(logic [NW-1:0] n);
    lane_t r;
    r.rem = DW'(n[NW-1:34]);
    r.dq  = {n[33:0], {FRAC_BITS{1'b0}}};
    return r;
  endfunction

  // One divider stage: step both quotient lanes and carry the rest along.
  function automatic div_t div_step(div_t s);
    div_t r;
    r    = s;
    r.lx = lane_step(s.lx, s.d);
    r.ly = lane_step(s.ly, s.d);
    return r;
  endfunction

  // Configuration registers.
  logic [CfgDataW-1:0] mat_q [0:5];
  logic [SizeW-1:0]    width_q;
  logic [SizeW-1:0]    height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        mat_q[i] <= '0;
      end
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRow0C01: mat_q[0] <= cfg_wdata_i;
        CfgRow0C23: mat_q[1] <= cfg_wdata_i;
        CfgRow1C01: mat_q[2] <= cfg_wdata_i;
        CfgRow1C23: mat_q[3] <= cfg_wdata_i;
        CfgWrowC01: mat_q[4] <= cfg_wdata_i;
        CfgWrowC23: mat_q[5] <= cfg_wdata_i;
        CfgWidth:   width_q  <= cfg_wdata_i[SizeW-1:0];
        CfgHeight:  height_q <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Valid bits: three front stages, divider stages, output.
  logic              v1_q, v2_q, v3_q;
  logic [QW:0]       vd_q;
  logic              vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vd_q <= '0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vd_q <= {vd_q[QW-1:0], v3_q};
      vo_q <= vd_q[QW];
    end
  end

  // Stage 1: the nine matrix products.
  logic signed [CoordW-1:0] coord [0:2];
  logic signed [ProdW-1:0]  prod_q [0:2][0:2];

  assign coord[0] = point_i.point_x;
  assign coord[1] = point_i.point_y;
  assign coord[2] = point_i.point_z;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= ProdW'($signed(mat_q[2*r + c/2][(c%2)*32 +: 32])) *
                        ProdW'(coord[c]);
      end
    end
  end

  // Stage 2: floor to Q format, add the translation column, saturate.
  logic signed [CoordW-1:0] clip_q [0:2];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      clip_q[r] <= sat32(SumW'(prod_q[r][0] >>> FRAC_BITS) +
                         SumW'(prod_q[r][1] >>> FRAC_BITS) +
                         SumW'(prod_q[r][2] >>> FRAC_BITS) +
                         SumW'($signed(mat_q[2*r + 1][63:32])));
    end
  end

  // Stage 3: behind test, scaled clip values, numerators and divisor.
  logic                     behind_q;
  logic signed [CoordW-1:0] bx_q, by_q;
  logic                     negx_q, negy_q;
  logic [NW-1:0]            nx_q, ny_q;
  logic [DW-1:0]            d_q;
  logic [CoordW-1:0]        magx, magy;

  assign magx = clip_q[0][CoordW-1] ? CoordW'(-clip_q[0]) : CoordW'(clip_q[0]);
  assign magy = clip_q[1][CoordW-1] ? CoordW'(-clip_q[1]) : CoordW'(clip_q[1]);

  always_ff @(posedge clk_i) begin
    behind_q <= clip_q[2] < Thr;
    bx_q     <= sat32(SumW'(ProdW'(clip_q[0]) * Behind));
    by_q     <= sat32(SumW'(ProdW'(clip_q[1]) * Behind));
    negx_q   <= clip_q[0][CoordW-1];
    negy_q   <= clip_q[1][CoordW-1];
    nx_q     <= NW'(magx) * NW'(width_q);
    ny_q     <= NW'(magy) * NW'(height_q);
    d_q      <= {clip_q[2], 1'b0};
  end

  // Divider pipeline: stage 0 seeds, each further stage retires one bit.
  div_t div_q [0:QW];
  div_t div_init;

  always_comb begin
    div_init.behind = behind_q;
    div_init.bx     = bx_q;
    div_init.by     = by_q;
    div_init.negx   = negx_q;
    div_init.negy   = negy_q;
    div_init.d      = d_q;
    div_init.ovfx   = DW'(nx_q[NW-1:34]) >= d_q;
    div_init.ovfy   = DW'(ny_q[NW-1:34]) >= d_q;
    div_init.lx     = lane_init(nx_q);
    div_init.ly     = lane_init(ny_q);
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= div_init;
    for (int i = 0; i < QW; i++) begin
      div_q[i+1] <= div_step(div_q[i]);
    end
  end

  // Output stage: restore signs, map to pixels, saturate.
  div_t                 fin;
  logic [QW-1:0]        tx, ty;
  logic signed [SW-1:0] sx, sy, ax, ay, half, sxs, sys;
  result_t              res_d, res_q;

  assign fin  = div_q[QW];
  assign tx   = fin.ovfx ? '1 : fin.lx.dq;
  assign ty   = fin.ovfy ? '1 : fin.ly.dq;
  assign sx   = fin.negx ? -$signed({2'b00, tx}) : $signed({2'b00, tx});
  assign sy   = fin.negy ? -$signed({2'b00, ty}) : $signed({2'b00, ty});
  assign ax   = SW'(width_q >> 1) <<< FRAC_BITS;
  assign ay   = SW'(height_q >> 1) <<< FRAC_BITS;
  assign half = SW'(1) <<< (FRAC_BITS - 1);
  assign sxs  = ax + sx + half;
  assign sys  = ay - (sy + half);

  always_comb begin
    if (fin.behind) begin
      res_d.visible  = 1'b0;
      res_d.screen_x = fin.bx;
      res_d.screen_y = fin.by;
    end else begin
      res_d.visible  = 1'b1;
      res_d.screen_x = sat32(SumW'(sxs));
      res_d.screen_y = sat32(SumW'(sys));
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = vo_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pws_pkg::*;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned Latency   = FracBits + 39;
  localparam int unsigned IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  point_t point_i = '0;
  logic done_o;
  result_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Shadow copy of the configuration registers.
  logic [CfgDataW-1:0] mat_regs [6];
  logic [SizeW-1:0] view_w, view_h;

  result_t projections_due [$];
  int err_cnt = 0;
  int idle_cycles = 0;

  perspective_world_to_screen #(.FRAC_BITS(FracBits)) DUT (
    .clk_i, .rst_ni, .start, .busy, .point_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mat_entry(int row, int col);
    logic [63:0] r;
    logic signed [31:0] e;
    r = mat_regs[row * 2 + col / 2];
    e = (col % 2) ? r[63:32] : r[31:0];
    return longint'(e);
  endfunction

  // Row dot product: each product floored to Q16.16, then summed and clamped.
  function automatic longint clip_row(int row, longint px, longint py, longint pz);
    longint s;
    s = ((mat_entry(row, 0) * px) >>> FracBits) + ((mat_entry(row, 1) * py) >>> FracBits)
      + ((mat_entry(row, 2) * pz) >>> FracBits) + mat_entry(row, 3);
    return sat32(s);
  endfunction

  // (c * size) / d, magnitude-truncated with integer part limited to 2^33.
  function automatic longint scaled_quot(longint c, longint size, longint d);
    logic [63:0] mag, n, q, r, t;
    mag = (c < 0) ? -c : c;
    n = mag * size;
    q = n / d;
    r = n % d;
    if (q > (64'd1 << 33)) q = 64'd1 << 33;
    t = (q << FracBits) + (r << FracBits) / d;
    return (c < 0) ? -longint'(t) : longint'(t);
  endfunction

  function automatic result_t project_point(point_t p);
    result_t res;
    longint cx, cy, cw, thr, w, h;
    cx = clip_row(0, p.point_x, p.point_y, p.point_z);
    cy = clip_row(1, p.point_x, p.point_y, p.point_z);
    cw = clip_row(2, p.point_x, p.point_y, p.point_z);
    thr = ((64'sd1 << FracBits) + 999) / 1000;
    w = view_w;
    h = view_h;
    if (cw < thr) begin
      res.visible = 1'b0;
      res.screen_x = 32'(sat32(cx * 100000));
      res.screen_y = 32'(sat32(cy * 100000));
    end else begin
      res.visible = 1'b1;
      res.screen_x = 32'(sat32((w / 2) * (64'sd1 << FracBits)
                     + scaled_quot(cx, w, 2 * cw) + (64'sd1 << (FracBits - 1))));
      res.screen_y = 32'(sat32((h / 2) * (64'sd1 << FracBits)
                     - (scaled_quot(cy, h, 2 * cw) + (64'sd1 << (FracBits - 1)))));
    end
    return res;
  endfunction

  // Check each result transaction against the oldest expected projection.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (projections_due.size() == 0) begin
        $error("result with no transaction outstanding");
        err_cnt++;
      end else begin
        result_t exp_r;
        exp_r = projections_due.pop_front();
        if (result_o.visible !== exp_r.visible) begin
          $error("visible: expected %0d, got %0d", exp_r.visible, result_o.visible);
          err_cnt++;
        end
        if (result_o.screen_x !== exp_r.screen_x) begin
          $error("screen_x: expected %0d, got %0d", exp_r.screen_x, result_o.screen_x);
          err_cnt++;
        end
        if (result_o.screen_y !== exp_r.screen_y) begin
          $error("screen_y: expected %0d, got %0d", exp_r.screen_y, result_o.screen_y);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction in either direction.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx < 6) mat_regs[idx] = val;
    else if (idx == CfgWidth) view_w = val[SizeW-1:0];
    else view_h = val[SizeW-1:0];
  endtask

  task automatic set_matrix(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                            logic [63:0] r1b, logic [63:0] wa, logic [63:0] wb,
                            logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    write_reg(CfgRow0C01, r0a);
    write_reg(CfgRow0C23, r0b);
    write_reg(CfgRow1C01, r1a);
    write_reg(CfgRow1C23, r1b);
    write_reg(CfgWrowC01, wa);
    write_reg(CfgWrowC23, wb);
    write_reg(CfgWidth, 64'(w));
    write_reg(CfgHeight, 64'(h));
    cfg_we_i <= 1'b0;
  endtask

  // Send one point, after a random gap, and record its expected projection.
  task automatic send_point(point_t p);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    point_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    projections_due.push_back(project_point(p));
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    while (projections_due.size() != 0 && guard < 10 * Latency) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 2000 << 16)) - (1000 << 16));
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    p.point_z = rand_coord();
    return p;
  endfunction

  // Reset defaults: zero matrix, so every point falls behind the viewer.
  task automatic test_reset_defaults;
    send_point('{32'sd65536, -32'sd65536, 32'sd0});
    send_point('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
    drain();
  endtask

  // Identity-like camera; w taken from z; edge coordinates and threshold.
  task automatic test_directed;
    set_matrix(64'h0000_0000_0001_0000, 64'h0,
               64'h0001_0000_0000_0000, 64'h0,
               64'h0, 64'h0000_0000_0001_0000, 14'd1920, 14'd1080);
    send_point('{32'sd0, 32'sd0, 32'sd65536});
    send_point('{32'sd32768, -32'sd32768, 32'sd65536});
    send_point('{32'sd65536, 32'sd65536, 32'sd66});
    send_point('{32'sd65536, 32'sd65536, 32'sd65});
    send_point('{32'sd65536, 32'sd65536, -32'sd65536});
    send_point('{32'h7FFFFFFF, 32'h80000000, 32'sd66});
    send_point('{32'h80000000, 32'h7FFFFFFF, 32'sd1000});
    send_point('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    send_point('{32'h80000000, 32'h80000000, 32'h80000000});
    send_point('{32'hFFFFFFFF, 32'h00000001, 32'sd67});
    drain();
    // Extreme entries force clip saturation; extreme viewport sizes.
    set_matrix(64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
               64'h8000_0000_7FFF_FFFF, 64'hFFFF_FFFF_0000_0001,
               64'h0000_0000_0000_0000, 64'h7FFF_FFFF_0000_0001, 14'd8192, 14'd1);
    send_point('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
    send_point('{32'sd1, 32'sd1, 32'sd1});
    send_point('{32'h80000000, 32'h7FFFFFFF, 32'sd0});
    drain();
    set_matrix(64'h0000_0000_0001_0000, 64'h0,
               64'h0001_0000_0000_0000, 64'h0,
               64'h0, 64'h0000_0000_0001_0000, 14'd0, 14'h3FFF);
    send_point('{32'sd65536, 32'sd65536, 32'sd66});
    send_point('{-32'sd65536, -32'sd65536, 32'sd131072});
    drain();
  endtask

  // Random points under a series of random and structured camera settings.
  task automatic test_random;
    logic [SizeW-1:0] w, h;
    for (int ph = 0; ph < 10; ph++) begin
      w = (ph % 3 == 0) ? 14'($urandom_range(1, 8192)) : 14'($urandom_range(1, 2048));
      h = (ph % 4 == 1) ? 14'($urandom) : 14'($urandom_range(1, 2048));
      if (ph % 2 == 0)
        set_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   w, h);
      else
        set_matrix({32'($urandom_range(0, 65536)), 32'($urandom_range(0, 131072))},
                   {32'($urandom_range(0, 65536)), 32'($urandom_range(0, 65536))},
                   {32'($urandom_range(0, 131072)), 32'($urandom_range(0, 65536))},
                   {32'($urandom_range(0, 65536)), 32'($urandom_range(0, 65536))},
                   {32'($urandom_range(0, 4096)), 32'($urandom_range(0, 4096))},
                   {32'($urandom_range(0, 65536)), 32'($urandom_range(0, 65536))},
                   w, h);
      for (int i = 0; i < 100; i++) send_point(rand_point());
      drain();
    end
  endtask

  initial begin
    mat_regs = '{default: '0};
    view_w = WidthRst;
    view_h = HeightRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random();
    if (err_cnt == 0 && projections_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/pws_pkg.sv
rtl/core/perspective_world_to_screen.sv
sim/tb_top.sv
